// ----- rtl/jru_pkg.sv -----
// shared constants and codes for the jacobi rotation unit
package jru_pkg;

	// data width of the rotated elements and the saturation range it implies
	localparam int DATA_WIDTH = 32;
	localparam int SAT_BITS   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

	// largest positive rotate result, as a 35 bit magnitude
	localparam logic [34:0] SAT_POS = 35'((64'd1 << (SAT_BITS - 1)) - 64'd1);

	// fixed point one in q1.30 and its square in q4.60
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
	localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;

	// operation codes carried on tuser
	localparam logic OP_SETUP  = 1'b0;
	localparam logic OP_ROTATE = 1'b1;

endpackage

// ----- rtl/jacobi_rotation_unit_core.sv -----
// jacobi rotation unit: setup of c and s from a 2x2 block, rotation of element pairs
// setup item: three 64-step divisions, two 32-step square roots and three products, then
//   the result register; a zero off-diagonal goes straight to it with c one and s zero
// rotate item: four products, rounded as the result register loads; one item at a time,
//   the result register frees the input side while it waits
// reset (arst_n low, asynchronous) sets c to one, s to zero and empties the result register
module jacobi_rotation_unit_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// off_diagonal, diag_first, diag_second, first_in, second_in
	input  logic [159:0] s_tdata,
	// operation
	input  logic [0:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// first_out, second_out, cos_out, sin_out, zero pad
	output logic [127:0] m_tdata,
	output logic         m_tlast
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIVP = 4'd1;
	localparam logic [3:0] ST_MULP = 4'd2;
	localparam logic [3:0] ST_SQH  = 4'd3;
	localparam logic [3:0] ST_DIVT = 4'd4;
	localparam logic [3:0] ST_MULT = 4'd5;
	localparam logic [3:0] ST_SQW  = 4'd6;
	localparam logic [3:0] ST_DIVC = 4'd7;
	localparam logic [3:0] ST_MULS = 4'd8;
	localparam logic [3:0] ST_ROT  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0]         state_q;
	logic [5:0]         cnt_q;
	logic               op_q, last_q, le_q, neg_q;
	logic [30:0]        pq_q, tm_q, cos_q;
	logic [31:0]        sin_q, x0_q, x1_q;
	logic signed [64:0] acc0_q, acc1_q;
	logic [63:0]        div_nq_q;
	logic [33:0]        div_rem_q;
	logic [32:0]        div_den_q;
	logic [63:0]        sq_x_q;
	logic [33:0]        sq_rem_q;
	logic [31:0]        sq_root_q;
	logic signed [65:0] prod_q;
	logic               out_valid_q, out_last_q;
	logic [31:0]        out_f0_q, out_f1_q, out_sin_q;
	logic [30:0]        out_cos_q;

	// input field views
	logic [31:0] in_off, in_d1, in_d2, in_x0, in_x1;
	assign in_off = s_tdata[31:0];
	assign in_d1  = s_tdata[63:32];
	assign in_d2  = s_tdata[95:64];
	assign in_x0  = s_tdata[127:96];
	assign in_x1  = s_tdata[159:128];

	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// setup operands: |d1-d2|, 2|a| and the first division
	logic signed [32:0] num_s;
	logic [32:0]        n_abs, d_in, top_sel, den_sel;
	logic [31:0]        a_abs;
	logic               le_in;
	assign num_s   = $signed({in_d1[31], in_d1}) - $signed({in_d2[31], in_d2});
	assign n_abs   = num_s[32] ? 33'(-num_s) : 33'(num_s);
	assign a_abs   = in_off[31] ? 32'(-in_off) : in_off;
	assign d_in    = {a_abs, 1'b0};
	assign le_in   = (n_abs <= d_in);
	assign top_sel = le_in ? n_abs : d_in;
	assign den_sel = le_in ? d_in : n_abs;

	// shared restoring divider step
	logic [33:0] div_t, div_rem_n;
	logic        div_ge;
	logic [63:0] div_nq_n;
	assign div_t     = {div_rem_q[32:0], div_nq_q[63]};
	assign div_ge    = (div_t >= {1'b0, div_den_q});
	assign div_rem_n = div_ge ? (div_t - {1'b0, div_den_q}) : div_t;
	assign div_nq_n  = {div_nq_q[62:0], div_ge};

	// shared digit-by-digit square root step, rounded at the end
	logic [35:0] sq_t, sq_trial, sq_rem_n;
	logic        sq_ge;
	logic [31:0] sq_root_n;
	logic [32:0] sq_round;
	logic [31:0] sq_res;
	assign sq_t      = {sq_rem_q, sq_x_q[63:62]};
	assign sq_trial  = {2'b00, sq_root_q, 2'b01};
	assign sq_ge     = (sq_t >= sq_trial);
	assign sq_rem_n  = sq_ge ? (sq_t - sq_trial) : sq_t;
	assign sq_root_n = {sq_root_q[30:0], sq_ge};
	assign sq_round  = {1'b0, sq_root_n} + 33'(sq_rem_n > {4'b0, sq_root_n});
	assign sq_res    = sq_round[31:0];

	// second division operands, chosen by the branch taken
	logic [32:0] den_t;
	logic [63:0] num_t;
	assign den_t = le_q ? ({2'b0, pq_q} + {1'b0, sq_res})
	                    : ({2'b0, jru_pkg::ONE_Q30} + {1'b0, sq_res});
	assign num_t = le_q ? (jru_pkg::ONE_Q60 + {32'b0, den_t[32:1]})
	                    : ({3'b0, pq_q, 30'b0} + {32'b0, den_t[32:1]});

	// shared multiplier operand select
	logic signed [32:0] mul_a, mul_b;
	always_comb begin
		case (state_q)
			ST_MULP: begin
				mul_a = {2'b0, pq_q};
				mul_b = {2'b0, pq_q};
			end
			ST_MULT: begin
				mul_a = {2'b0, tm_q};
				mul_b = {2'b0, tm_q};
			end
			ST_MULS: begin
				mul_a = {2'b0, cos_q};
				mul_b = {2'b0, tm_q};
			end
			ST_ROT: begin
				case (cnt_q[1:0])
					2'd0: begin
						mul_a = {x0_q[31], x0_q};
						mul_b = {2'b0, cos_q};
					end
					2'd1: begin
						mul_a = {x1_q[31], x1_q};
						mul_b = {sin_q[31], sin_q};
					end
					2'd2: begin
						mul_a = {x1_q[31], x1_q};
						mul_b = {2'b0, cos_q};
					end
					default: begin
						mul_a = {x0_q[31], x0_q};
						mul_b = {sin_q[31], sin_q};
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// sine magnitude from c*tm
	logic [63:0] smag_sum;
	assign smag_sum = prod_q[63:0] + jru_pkg::HALF_Q30;

	// round to nearest, ties away from zero, then saturate
	function automatic logic [31:0] round_sat(input logic signed [64:0] acc);
		logic [64:0] mag;
		logic [64:0] sum;
		logic [34:0] r;
		logic [34:0] lo;
		mag = acc[64] ? 65'(-acc) : 65'(acc);
		sum = mag + 65'(jru_pkg::HALF_Q30);
		r   = sum[64:30];
		lo  = ~jru_pkg::SAT_POS;
		if (acc[64]) begin
			if (r > jru_pkg::SAT_POS + 35'd1) begin
				round_sat = lo[31:0];
			end else begin
				round_sat = 32'(-r);
			end
		end else begin
			if (r > jru_pkg::SAT_POS) begin
				round_sat = jru_pkg::SAT_POS[31:0];
			end else begin
				round_sat = r[31:0];
			end
		end
	endfunction

	logic out_free;
	assign out_free = !out_valid_q || m_tready;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cos_q       <= jru_pkg::ONE_Q30;
			sin_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register load and drain
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (s_tuser[0] == jru_pkg::OP_ROTATE) begin
							state_q <= ST_ROT;
						end else if (d_in == '0) begin
							cos_q   <= jru_pkg::ONE_Q30;
							sin_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIVP;
						end
					end
				end
				ST_DIVP, ST_DIVT, ST_DIVC: begin
					if (cnt_q == 6'd63) begin
						cnt_q <= '0;
						if (state_q == ST_DIVP) begin
							state_q <= ST_MULP;
						end else if (state_q == ST_DIVT) begin
							state_q <= ST_MULT;
						end else begin
							cos_q   <= div_nq_n[30:0];
							state_q <= ST_MULS;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_MULP, ST_MULT: begin
					if (cnt_q[0]) begin
						cnt_q   <= '0;
						state_q <= (state_q == ST_MULP) ? ST_SQH : ST_SQW;
					end else begin
						cnt_q <= 6'd1;
					end
				end
				ST_SQH, ST_SQW: begin
					if (cnt_q == 6'd31) begin
						cnt_q   <= '0;
						state_q <= (state_q == ST_SQH) ? ST_DIVT : ST_DIVC;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_MULS: begin
					if (cnt_q[0]) begin
						sin_q   <= neg_q ? 32'(-{1'b0, smag_sum[60:30]})
						                 : {1'b0, smag_sum[60:30]};
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= 6'd1;
					end
				end
				ST_ROT: begin
					if (cnt_q == 6'd4) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q      <= s_tuser[0];
					last_q    <= s_tlast;
					x0_q      <= in_x0;
					x1_q      <= in_x1;
					le_q      <= le_in;
					neg_q     <= (num_s != '0) && (num_s[32] != in_off[31]);
					div_nq_q  <= {1'b0, top_sel, 30'b0} + {32'b0, den_sel[32:1]};
					div_den_q <= den_sel;
					div_rem_q <= '0;
				end
			end
			ST_DIVP, ST_DIVT, ST_DIVC: begin
				div_nq_q  <= div_nq_n;
				div_rem_q <= div_rem_n;
				if (cnt_q == 6'd63) begin
					if (state_q == ST_DIVP) begin
						pq_q <= div_nq_n[30:0];
					end else if (state_q == ST_DIVT) begin
						tm_q <= div_nq_n[30:0];
					end
				end
			end
			ST_MULP, ST_MULT: begin
				if (cnt_q[0]) begin
					sq_x_q    <= jru_pkg::ONE_Q60 + prod_q[63:0];
					sq_rem_q  <= '0;
					sq_root_q <= '0;
				end
			end
			ST_SQH, ST_SQW: begin
				sq_x_q    <= {sq_x_q[61:0], 2'b00};
				sq_rem_q  <= sq_rem_n[33:0];
				sq_root_q <= sq_root_n;
				if (cnt_q == 6'd31) begin
					div_rem_q <= '0;
					if (state_q == ST_SQH) begin
						div_nq_q  <= num_t;
						div_den_q <= den_t;
					end else begin
						div_nq_q  <= jru_pkg::ONE_Q60 + {33'b0, sq_res[31:1]};
						div_den_q <= {1'b0, sq_res};
					end
				end
			end
			ST_ROT: begin
				case (cnt_q[2:0])
					3'd1: acc0_q <= 65'(prod_q);
					3'd2: acc0_q <= acc0_q + 65'(prod_q);
					3'd3: acc1_q <= 65'(prod_q);
					3'd4: acc1_q <= acc1_q - 65'(prod_q);
					default: begin
					end
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					out_cos_q  <= cos_q;
					out_sin_q  <= sin_q;
					out_last_q <= (op_q == jru_pkg::OP_ROTATE) ? last_q : 1'b0;
					if (op_q == jru_pkg::OP_ROTATE) begin
						out_f0_q <= round_sat(acc0_q);
						out_f1_q <= round_sat(acc1_q);
					end else begin
						out_f0_q <= '0;
						out_f1_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result port
	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_sin_q, out_cos_q, out_f1_q, out_f0_q};

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input side still ready after accept");
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		cos_q <= jru_pkg::ONE_Q30)
		else $error("cosine above one");
	a_sin_range: assert property (@(posedge clk) disable iff (!arst_n)
		($signed(sin_q) <= $signed(32'h4000_0000)) &&
		($signed(sin_q) >= $signed(32'hC000_0000)))
		else $error("sine out of range");
	a_rot_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT) |-> (op_q == jru_pkg::OP_ROTATE))
		else $error("rotation sequence on a setup item");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && out_free) |=> (m_tvalid && s_tready))
		else $error("result not posted when leaving done");

endmodule

// ----- dv/tb_top.sv -----
// testbench for the jacobi rotation unit: directed and random stream stimulus checked against a rotation predictor
`timescale 1ns / 100ps

module tb_top;

	typedef struct {
		logic        op;
		logic [31:0] off_diag;
		logic [31:0] d_first;
		logic [31:0] d_second;
		logic [31:0] x_first;
		logic [31:0] x_second;
		logic        last;
	} pair_item_t;

	typedef struct {
		logic [31:0] first_v;
		logic [31:0] second_v;
		logic [30:0] cos_v;
		logic [31:0] sin_v;
		logic        last;
	} rot_result_t;

	localparam int LIMIT_CYCLES = 3000000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         m_tlast;

	pair_item_t  pending_items[$];
	rot_result_t expected_results[$];
	pair_item_t  held_item;
	logic [63:0] cur_cos;
	longint      cur_sin;
	int          send_gap;
	int          recv_gap;
	int          mismatches;
	int          cycle_count;
	bit          calm_phase;

	jacobi_rotation_unit_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// rounded division, ties upward
	function automatic logic [63:0] div_round(logic [63:0] x, logic [63:0] y);
		return (x + (y >> 1)) / y;
	endfunction

	// square root rounded to nearest
	function automatic logic [63:0] sqrt_round(logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] r;
		logic [63:0] b;
		rem = x;
		r = 0;
		b = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (x - r * r > r)
			r = r + 1;
		return r;
	endfunction

	// product sum to q16.16, ties away from zero, saturated
	function automatic logic [31:0] scale_sat(longint p);
		logic [63:0] mag;
		longint      hi;
		hi = (longint'(1) <<< (jru_pkg::SAT_BITS - 1)) - 1;
		mag = (p < 0) ? 64'(-p) : 64'(p);
		mag = (mag + (64'd1 << 29)) >> 30;
		if (p < 0) begin
			if (mag > 64'(hi) + 1)
				return 32'(-hi - 1);
			return 32'(-longint'(mag));
		end
		if (mag > 64'(hi))
			return 32'(hi);
		return 32'(mag);
	endfunction

	// new c and s from a symmetric 2x2 block
	task automatic schur_setup(longint a, longint d1, longint d2);
		longint      num;
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] pq;
		logic [63:0] h;
		logic [63:0] tm;
		logic [63:0] w;
		logic [63:0] c;
		logic [63:0] smag;
		num = d1 - d2;
		n = (num < 0) ? 64'(-num) : 64'(num);
		d = (a < 0) ? 64'(-a) * 2 : 64'(a) * 2;
		if (d == 0) begin
			cur_cos = 64'(jru_pkg::ONE_Q30);
			cur_sin = 0;
		end else begin
			if (n <= d) begin
				pq = div_round(n << 30, d);
				h = sqrt_round(jru_pkg::ONE_Q60 + pq * pq);
				tm = div_round(jru_pkg::ONE_Q60, pq + h);
			end else begin
				pq = div_round(d << 30, n);
				h = sqrt_round(jru_pkg::ONE_Q60 + pq * pq);
				tm = div_round(pq << 30, 64'(jru_pkg::ONE_Q30) + h);
			end
			w = sqrt_round(jru_pkg::ONE_Q60 + tm * tm);
			c = div_round(jru_pkg::ONE_Q60, w);
			smag = div_round(c * tm, 64'(jru_pkg::ONE_Q30));
			cur_cos = c;
			cur_sin = (num != 0 && ((num < 0) != (a < 0))) ? -longint'(smag) : longint'(smag);
		end
	endtask

	// expected result of one accepted item
	task automatic predict_rotation(pair_item_t it);
		rot_result_t r;
		longint      x0;
		longint      x1;
		longint      c;
		r.first_v = '0;
		r.second_v = '0;
		r.last = 1'b0;
		if (it.op == jru_pkg::OP_SETUP) begin
			schur_setup(longint'(signed'(it.off_diag)), longint'(signed'(it.d_first)),
				longint'(signed'(it.d_second)));
		end else begin
			x0 = longint'(signed'(it.x_first));
			x1 = longint'(signed'(it.x_second));
			c = longint'(cur_cos);
			r.first_v = scale_sat(x0 * c + x1 * cur_sin);
			r.second_v = scale_sat(x1 * c - x0 * cur_sin);
			r.last = it.last;
		end
		r.cos_v = cur_cos[30:0];
		r.sin_v = 32'(cur_sin);
		expected_results.insert(expected_results.size(), r);
	endtask

	function automatic int pick_gap();
		int k;
		if (calm_phase)
			return 0;
		k = $urandom_range(0, 19);
		if (k < 11)
			return 0;
		if (k < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// random q16.16 value: full range, small, or extreme
	function automatic logic [31:0] rand_q16();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4)
			return $urandom;
		if (k < 8)
			return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return 32'h0000_0001;
		endcase
	endfunction

	task automatic add_item(logic op, logic [31:0] a, logic [31:0] d1, logic [31:0] d2,
		logic [31:0] x0, logic [31:0] x1, logic last);
		pair_item_t it;
		it.op = op;
		it.off_diag = a;
		it.d_first = d1;
		it.d_second = d2;
		it.x_first = x0;
		it.x_second = x1;
		it.last = last;
		pending_items.insert(pending_items.size(), it);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			s_tlast <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_rotation(held_item);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0 || pending_items.size() == 0) begin
					s_tvalid <= 1'b0;
					if (send_gap > 0)
						send_gap <= send_gap - 1;
				end else begin
					held_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {held_item.x_second, held_item.x_first, held_item.d_second,
						held_item.d_first, held_item.off_diag};
					s_tuser <= held_item.op;
					s_tlast <= held_item.last;
					send_gap <= pick_gap();
				end
			end
		end
	end

	// monitor and result backpressure
	always @(posedge clk or negedge arst_n) begin
		rot_result_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected result item: %h last %b", m_tdata, m_tlast);
				end else begin
					e = expected_results.pop_front();
					if (m_tdata[31:0] !== e.first_v || m_tdata[63:32] !== e.second_v ||
						m_tdata[94:64] !== e.cos_v || m_tdata[126:95] !== e.sin_v ||
						m_tlast !== e.last) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: exp first %h second %h cos %h sin %h last %b, got %h %h %h %h %b",
								e.first_v, e.second_v, e.cos_v, e.sin_v, e.last,
								m_tdata[31:0], m_tdata[63:32], m_tdata[94:64],
								m_tdata[126:95], m_tlast);
					end
				end
			end
			if (recv_gap > 0) begin
				m_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid && m_tready)
					recv_gap <= pick_gap();
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		int k;
		mismatches = 0;
		cycle_count = 0;
		calm_phase = 1'b0;
		cur_cos = 64'(jru_pkg::ONE_Q30);
		cur_sin = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;

		// rotate before any setup uses c one, s zero
		add_item(jru_pkg::OP_ROTATE, 32'h1234_5678, 32'h1, 32'h2, 32'h0001_0000, 32'hfffe_0000,
			1'b0);
		add_item(jru_pkg::OP_ROTATE, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
		// zero off-diagonal
		add_item(jru_pkg::OP_SETUP, 32'h0, 32'h0003_0000, 32'h0001_0000, 32'h5, 32'h6, 1'b1);
		add_item(jru_pkg::OP_ROTATE, 32'h0, 32'h0, 32'h0, 32'h0002_8000, 32'h0001_0000, 1'b0);
		// equal diagonals
		add_item(jru_pkg::OP_SETUP, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0, 32'h0,
			1'b0);
		add_item(jru_pkg::OP_ROTATE, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		add_item(jru_pkg::OP_ROTATE, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0);
		add_item(jru_pkg::OP_ROTATE, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
		// negative off-diagonal with equal diagonals
		add_item(jru_pkg::OP_SETUP, 32'hffff_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
		add_item(jru_pkg::OP_ROTATE, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
		// extremes of the block
		add_item(jru_pkg::OP_SETUP, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0,
			1'b1);
		add_item(jru_pkg::OP_ROTATE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'h1, 1'b1);
		add_item(jru_pkg::OP_SETUP, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0,
			1'b0);
		add_item(jru_pkg::OP_ROTATE, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
		add_item(jru_pkg::OP_SETUP, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0,
			1'b0);
		add_item(jru_pkg::OP_ROTATE, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0);
		add_item(jru_pkg::OP_SETUP, 32'hffff_ffff, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 1'b0);
		add_item(jru_pkg::OP_ROTATE, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1'b1);

		// random mix: setups followed by runs of rotates
		for (k = 0; k < 1050; k++) begin
			if ($urandom_range(0, 9) < 2)
				add_item(jru_pkg::OP_SETUP, rand_q16(), rand_q16(), rand_q16(), $urandom,
					$urandom, 1'($urandom));
			else
				add_item(jru_pkg::OP_ROTATE, $urandom, $urandom, $urandom, rand_q16(),
					rand_q16(), 1'($urandom));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// alternate stretches with and without idling
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0) begin
			repeat (500) @(posedge clk);
			calm_phase = ($urandom_range(0, 3) == 0);
		end
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- jacobi_rotation_unit_core.f -----
rtl/jru_pkg.sv
rtl/jacobi_rotation_unit_core.sv
dv/tb_top.sv
